// File: design/u8s_pkg.sv
package u8s_pkg;

	localparam int UNIT_W          = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [UNIT_W-1:0] MAX_UNITS_RESET = '1;

	// Lead byte ranges of the strict UTF-8 rules.
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] LEAD_SURR  = 8'hED;
	localparam logic [7:0] SEC_E0_MIN = 8'hA0;
	localparam logic [7:0] SEC_ED_LIM = 8'hA0;
	localparam logic [7:0] SEC_F0_MIN = 8'h90;
	localparam logic [7:0] SEC_F4_LIM = 8'h90;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// U+FFFD as UTF-8; element 0 goes out first.
	localparam logic [2:0][7:0] REPL_SEQ = {8'hBD, 8'hBF, 8'hEF};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              byte_present;
		logic              end_of_text;
		logic              was_truncated;
		logic [UNIT_W-1:0] units_used;
	} out_t;

	// One character found by the front end.
	typedef struct packed {
		logic       rep;
		logic [1:0] pos;
		logic [2:0] len;
	} char_t;

	// Everything the back end needs for one accepted byte.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		char_t [3:0]     chars;
		logic [2:0]      nchar;
		logic            closing;
	} entry_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] l;
		l = 3'd0;
		if (b <= ASCII_MAX) begin
			l = 3'd1;
		end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
			l = 3'd2;
		end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
			l = 3'd3;
		end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
			l = 3'd4;
		end
		return l;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] s);
		return is_cont(s)
			&& !(lead == LEAD3_MIN && s < SEC_E0_MIN)
			&& !(lead == LEAD_SURR && s >= SEC_ED_LIM)
			&& !(lead == LEAD4_MIN && s < SEC_F0_MIN)
			&& !(lead == LEAD4_MAX && s >= SEC_F4_LIM);
	endfunction

endpackage

// File: design/u8s_front.sv
module u8s_front import u8s_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  in_t    in_data,
	output logic   in_stall,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	logic [2:0][7:0] held_q;
	logic [1:0]      held_cnt_q;

	logic [3:0][7:0] bufv;
	logic [2:0]      n_w;
	char_t [3:0]     chars_w;
	logic [2:0]      nch_w;
	logic [1:0]      hold_cnt_w;
	logic [2:0][7:0] hold_w;
	logic            accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Held bytes followed by the new byte; entries past the end are never read.
	always_comb begin
		bufv[0] = (held_cnt_q == 2'd0) ? in_data.in_byte : held_q[0];
		bufv[1] = (held_cnt_q == 2'd1) ? in_data.in_byte : held_q[1];
		bufv[2] = (held_cnt_q == 2'd2) ? in_data.in_byte : held_q[2];
		bufv[3] = in_data.in_byte;
		n_w     = {1'b0, held_cnt_q} + 3'd1;
	end

	// Split the buffer into characters, at most four, or hold an open prefix.
	always_comb begin
		logic [2:0] pos;
		logic [2:0] ln;
		logic [2:0] avail;
		logic [2:0] lim;
		logic       bad;
		logic       stop;
		logic [1:0] idx;
		pos        = 3'd0;
		ln         = 3'd0;
		avail      = 3'd0;
		lim        = 3'd0;
		bad        = 1'b0;
		idx        = 2'd0;
		stop       = 1'b0;
		nch_w      = 3'd0;
		chars_w    = '0;
		hold_cnt_w = 2'd0;
		hold_w     = held_q;
		for (int k = 0; k < 4; k++) begin
			if (!stop && pos < n_w) begin
				ln    = lead_len(bufv[pos[1:0]]);
				avail = n_w - pos;
				lim   = (avail < ln) ? avail : ln;
				bad   = (ln == 3'd0);
				for (int i = 1; i < 4; i++) begin
					idx = pos[1:0] + 2'(i);
					if (!bad && 3'(i) < lim) begin
						if (i == 1) begin
							bad = !second_ok(bufv[pos[1:0]], bufv[idx]);
						end else begin
							bad = !is_cont(bufv[idx]);
						end
					end
				end
				if (!bad && avail >= ln) begin
					chars_w[nch_w[1:0]].rep = (ln == 3'd1) && (bufv[pos[1:0]] == 8'h00);
					chars_w[nch_w[1:0]].pos = pos[1:0];
					chars_w[nch_w[1:0]].len = ln;
					nch_w = nch_w + 3'd1;
					pos   = pos + ln;
				end else if (!bad && !in_data.last_byte) begin
					hold_cnt_w = avail[1:0];
					for (int j = 0; j < 3; j++) begin
						if (3'(j) < avail) begin
							hold_w[j] = bufv[pos[1:0] + 2'(j)];
						end
					end
					stop = 1'b1;
				end else begin
					chars_w[nch_w[1:0]].rep = 1'b1;
					chars_w[nch_w[1:0]].pos = pos[1:0];
					chars_w[nch_w[1:0]].len = 3'd1;
					nch_w = nch_w + 3'd1;
					pos   = pos + 3'd1;
				end
			end
		end
	end

	assign push               = accept && (nch_w != 3'd0 || in_data.last_byte);
	assign push_entry.bytes   = bufv;
	assign push_entry.chars   = chars_w;
	assign push_entry.nchar   = nch_w;
	assign push_entry.closing = in_data.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= in_data.last_byte ? 2'd0 : hold_cnt_w;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= hold_w;
		end
	end

endmodule

// File: design/u8s_queue.sv
module u8s_queue import u8s_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output entry_t rd_entry,
	output logic   not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("entry pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("entry popped from an empty queue");
`endif

endmodule

// File: design/u8s_back.sv
module u8s_back import u8s_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            head,
	input  logic              head_valid,
	output logic              pop,
	input  logic [UNIT_W-1:0] max_units,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data
);

	logic [1:0]        ci_q;
	logic [1:0]        bi_q;
	logic [UNIT_W-1:0] counter_q;
	logic              limit_q;
	logic              out_valid_q;
	out_t              out_data_q;

	char_t             cur;
	char_t             nxt;
	logic [1:0]        u_w;
	logic [1:0]        un_w;
	logic [2:0]        usum_w;
	logic [2:0]        olen_w;
	logic [UNIT_W:0]   sum1_w;
	logic [UNIT_W:0]   nsum_w;
	logic [UNIT_W-1:0] post_w;
	logic              adv;
	logic              go;
	logic              first;
	logic              lastb;
	logic              fits;
	logic              fail;
	logic              has_next;
	logic              next_fit;
	logic              beat_w;
	out_t              beat_data_w;
	logic [1:0]        ci_d;
	logic [1:0]        bi_d;
	logic [UNIT_W-1:0] cnt_d;
	logic              lim_d;

	assign adv = !out_valid_q || !out_stall;
	assign go  = head_valid && adv;

	always_comb begin
		cur      = head.chars[ci_q];
		nxt      = head.chars[ci_q + 2'd1];
		u_w      = (!cur.rep && cur.len == 3'd4) ? 2'd2 : 2'd1;
		un_w     = (!nxt.rep && nxt.len == 3'd4) ? 2'd2 : 2'd1;
		olen_w   = cur.rep ? 3'd3 : cur.len;
		first    = (bi_q == 2'd0);
		lastb    = ({1'b0, bi_q} == olen_w - 3'd1);
		has_next = ({1'b0, ci_q} + 3'd1) < head.nchar;
		usum_w   = first ? ({1'b0, u_w} + {1'b0, un_w}) : {1'b0, un_w};
		sum1_w   = {1'b0, counter_q} + (UNIT_W + 1)'(u_w);
		nsum_w   = {1'b0, counter_q} + (UNIT_W + 1)'(usum_w);
		fits     = !limit_q && (sum1_w <= {1'b0, max_units});
		fail     = first && !fits;
		next_fit = has_next && (nsum_w <= {1'b0, max_units});
		post_w   = first ? sum1_w[UNIT_W-1:0] : counter_q;
	end

	always_comb begin
		pop         = 1'b0;
		beat_w      = 1'b0;
		beat_data_w = '0;
		ci_d        = ci_q;
		bi_d        = bi_q;
		cnt_d       = counter_q;
		lim_d       = limit_q;
		if (go) begin
			if (fail) begin
				// The character does not fit, and nothing after it will either.
				pop  = 1'b1;
				ci_d = 2'd0;
				bi_d = 2'd0;
				if (head.closing) begin
					beat_w                    = 1'b1;
					beat_data_w.end_of_text   = 1'b1;
					beat_data_w.was_truncated = 1'b1;
					beat_data_w.units_used    = counter_q;
					cnt_d                     = '0;
					lim_d                     = 1'b0;
				end else begin
					lim_d = 1'b1;
				end
			end else begin
				beat_w                   = 1'b1;
				beat_data_w.out_byte     = cur.rep ? REPL_SEQ[bi_q] : head.bytes[cur.pos + bi_q];
				beat_data_w.byte_present = 1'b1;
				beat_data_w.units_used   = post_w;
				cnt_d                    = post_w;
				if (lastb) begin
					if (head.closing && !next_fit) begin
						beat_data_w.end_of_text   = 1'b1;
						beat_data_w.was_truncated = has_next;
						cnt_d = '0;
						lim_d = 1'b0;
						pop   = 1'b1;
						ci_d  = 2'd0;
						bi_d  = 2'd0;
					end else if (has_next) begin
						ci_d = ci_q + 2'd1;
						bi_d = 2'd0;
					end else begin
						pop  = 1'b1;
						ci_d = 2'd0;
						bi_d = 2'd0;
					end
				end else begin
					bi_d = bi_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q        <= 2'd0;
			bi_q        <= 2'd0;
			counter_q   <= '0;
			limit_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ci_q      <= ci_d;
			bi_q      <= bi_d;
			counter_q <= cnt_d;
			limit_q   <= lim_d;
			if (adv) begin
				out_valid_q <= go && beat_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && beat_w) begin
			out_data_q <= beat_data_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_mid_char_not_limited: assert property (@(posedge clk) disable iff (!arst_n)
		(bi_q != 2'd0) |-> (!limit_q && head_valid))
		else $error("character interrupted by the unit limit");

	a_trunc_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.was_truncated) |-> out_data_q.end_of_text)
		else $error("truncation flag outside the closing beat");

	a_bare_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.byte_present) |-> out_data_q.end_of_text)
		else $error("beat without a byte that does not close the text");
`endif

endmodule

// File: design/utf8_sanitize_truncate_utf16.sv
// Strict UTF-8 sanitiser with a UTF-16 unit budget.
// Input channel: in_valid/in_stall carry one text byte per beat in in_data, with
// last_byte set on the final byte of a text. Output channel: out_valid/out_stall
// carry one output byte per beat in out_data; a closing beat has end_of_text set
// and, when no character from the closing byte fits the budget, byte_present is clear.
// cfg_we/cfg_data write max_units; the user must write it only while the block
// is idle, which the block itself does not enforce. Throughput: a byte is taken
// in every cycle while the internal queue has room. The back end sends one output
// beat per cycle while the receiver does not stall; a plain character gives its
// own bytes, a replacement character the three bytes of U+FFFD, and a character
// that fails the unit limit gives no byte. The output beat rate is the limit on
// sustained throughput. The first beat of a result is offered once the byte that
// completes it has passed through the queue and the output register.
// Reset: arst_n empties the queue, drops any partly received sequence, clears the
// unit counter and the limit flag, and sets max_units to its largest value.
// When the receiver stalls, the output register holds its beat and the queue
// fills; in_stall rises only once the queue is full.
module utf8_sanitize_truncate_utf16 import u8s_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [UNIT_W-1:0] cfg_data
);

	logic [UNIT_W-1:0] max_units_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	entry_t            q_wr;
	entry_t            q_rd;

	// The single configuration register: the unit budget of one text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= MAX_UNITS_RESET;
		end else if (cfg_we) begin
			max_units_q <= cfg_data;
		end
	end

	// Front end: joins the held bytes with the new one and splits them into
	// characters, keeping an incomplete but so far valid sequence for later.
	u8s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_wr)
	);

	// Queue between the two halves, so that each can stall on its own.
	u8s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.rd_entry  (q_rd),
		.not_empty (q_not_empty)
	);

	// Back end: applies the unit budget character by character and sends the
	// bytes out one beat at a time through the output register.
	u8s_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd),
		.head_valid (q_not_empty),
		.pop        (q_pop),
		.max_units  (max_units_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
